### design/ssc_pkg.sv
// Shared constants and types for the safe sequence checker.
`timescale 1ns / 1ps

package ssc_pkg;

    // Default sizing.
    localparam int MAX_PROCESSES_DEF = 8;
    localparam int MAX_RESOURCES_DEF = 4;
    localparam int VALUE_WIDTH_DEF   = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int PROC_CFG_W  = 4;
    localparam int RES_CFG_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESSES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESOURCES = 2'd1;

    localparam logic [PROC_CFG_W-1:0] PROC_CFG_RESET = 4'd8;
    localparam logic [RES_CFG_W-1:0]  RES_CFG_RESET  = 3'd4;

    // Input item kinds.
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_LOAD_CLAIM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_AVAIL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN        = 2'd2;

    // Fixed field widths of the stream payload.
    localparam int FIELD_VALUE_W = 8;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 8;
    localparam int CHOSEN_W      = 3;

    // Tag that follows a table read issued during a scan.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

endpackage

### design/ssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ssc_select.sv
// Scan datapath: per-process fit test, allocation sum and best-candidate tracking.
`timescale 1ns / 1ps

module ssc_select #(
    parameter int VALUE_WIDTH = 8,
    parameter int AVAIL_W     = 12,
    parameter int SUM_W       = 11,
    parameter int P_W         = 3,
    parameter int ADDR_W      = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  ssc_pkg::scan_tag_t     tag,
    input  logic [P_W-1:0]         tag_p,
    input  logic [ADDR_W-1:0]      tag_base,
    input  logic [VALUE_WIDTH-1:0] claim,
    input  logic [VALUE_WIDTH-1:0] alloc,
    input  logic [AVAIL_W-1:0]     avail,
    input  logic                   done_mark,
    output logic                   found,
    output logic [P_W-1:0]         best_p,
    output logic [ADDR_W-1:0]      best_base
);

    logic                   fit_acc_reg;
    logic [SUM_W-1:0]       sum_acc_reg;
    logic                   found_reg;
    logic [SUM_W-1:0]       best_sum_reg;
    logic [P_W-1:0]         best_p_reg;
    logic [ADDR_W-1:0]      best_base_reg;

    logic [VALUE_WIDTH-1:0] need;
    logic                   fit_now;
    logic [SUM_W-1:0]       sum_now;
    logic                   take;

    always_comb begin
        need    = (claim > alloc) ? (claim - alloc) : '0;
        fit_now = (tag.first | fit_acc_reg) & (AVAIL_W'(need) <= avail);
        sum_now = (tag.first ? '0 : sum_acc_reg) + SUM_W'(alloc);
        take    = tag.valid & tag.last & ~done_mark & fit_now
                  & (~found_reg | (sum_now > best_sum_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    // Accumulators and best candidate carry no reset.
    always_ff @(posedge aclk) begin
        if (tag.valid) begin
            fit_acc_reg <= fit_now;
            sum_acc_reg <= sum_now;
        end
        if (take) begin
            best_sum_reg  <= sum_now;
            best_p_reg    <= tag_p;
            best_base_reg <= tag_base;
        end
    end

    assign found     = found_reg;
    assign best_p    = best_p_reg;
    assign best_base = best_base_reg;

endmodule

### design/safe_sequence_checker_unit.sv
// Each scan reads the claim/allocation RAM one entry a cycle; the RAM port sets the pace.
// Load items produce no result; one item is handled at a time.
// Results leave through an output register, so the next pass overlaps a waiting result.
// Reset: synchronous active-low; clears control, finished marks and registers to 8 and 4.
`timescale 1ns / 1ps

module safe_sequence_checker_unit #(
    parameter int MAX_PROCESSES = ssc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = ssc_pkg::MAX_RESOURCES_DEF,
    parameter int VALUE_WIDTH   = ssc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // process_index[2:0], resource_index[4:3], max_claim[12:5],
    // allocated[20:13], available_amount[28:21], zero [31:29]
    input  logic [ssc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [ssc_pkg::KIND_W-1:0]      s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chosen_process[2:0], system_safe[3], zero [7:4]
    output logic [ssc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // is_verdict[0]
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int P_W     = $clog2(MAX_PROCESSES);
    localparam int R_W     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PC_W    = $clog2(MAX_PROCESSES + 1);
    localparam int RC_W    = $clog2(MAX_RESOURCES + 1);
    localparam int AVAIL_W = VALUE_WIDTH + 4;
    localparam int SUM_W   = VALUE_WIDTH + RC_W;
    localparam int FW      = ssc_pkg::FIELD_VALUE_W;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SCAN      = 8'b0000_0010,
        ST_SCAN_WAIT = 8'b0000_0100,
        ST_DECIDE    = 8'b0000_1000,
        ST_UPDATE    = 8'b0001_0000,
        ST_UPD_WAIT  = 8'b0010_0000,
        ST_EMIT      = 8'b0100_0000,
        ST_VERDICT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Input fields.
    logic [ssc_pkg::KIND_W-1:0] in_kind;
    logic [2:0]                 in_pidx;
    logic [1:0]                 in_ridx;
    logic [FW-1:0]              in_claim;
    logic [FW-1:0]              in_alloc;
    logic [FW-1:0]              in_avail;
    logic                       in_accept;
    logic                       pidx_ok;
    logic                       ridx_ok;

    assign in_kind   = s_axis_tuser;
    assign in_pidx   = s_axis_tdata[2:0];
    assign in_ridx   = s_axis_tdata[4:3];
    assign in_claim  = s_axis_tdata[12:5];
    assign in_alloc  = s_axis_tdata[20:13];
    assign in_avail  = s_axis_tdata[28:21];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign pidx_ok   = (32'(in_pidx) < MAX_PROCESSES);
    assign ridx_ok   = (32'(in_ridx) < MAX_RESOURCES);

    // Configuration registers.
    logic [ssc_pkg::PROC_CFG_W-1:0] proc_cfg_reg;
    logic [ssc_pkg::RES_CFG_W-1:0]  res_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_cfg_reg <= ssc_pkg::PROC_CFG_RESET;
            res_cfg_reg  <= ssc_pkg::RES_CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ssc_pkg::REG_PROCESSES: proc_cfg_reg <= cfg_wdata[ssc_pkg::PROC_CFG_W-1:0];
                ssc_pkg::REG_RESOURCES: res_cfg_reg  <= cfg_wdata[ssc_pkg::RES_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp counts into 1..max.
    logic [PC_W-1:0] nproc_run;
    logic [RC_W-1:0] nres_run;

    always_comb begin
        if (proc_cfg_reg == '0) begin
            nproc_run = PC_W'(1);
        end else if (32'(proc_cfg_reg) > MAX_PROCESSES) begin
            nproc_run = PC_W'(MAX_PROCESSES);
        end else begin
            nproc_run = PC_W'(proc_cfg_reg);
        end
        if (res_cfg_reg == '0) begin
            nres_run = RC_W'(1);
        end else if (32'(res_cfg_reg) > MAX_RESOURCES) begin
            nres_run = RC_W'(MAX_RESOURCES);
        end else begin
            nres_run = RC_W'(res_cfg_reg);
        end
    end

    // Run control registers.
    logic [PC_W-1:0]          nproc_reg;
    logic [RC_W-1:0]          nres_reg;
    logic [PC_W-1:0]          pass_reg, pass_next;
    logic [P_W-1:0]           scan_p_reg, scan_p_next;
    logic [R_W-1:0]           scan_r_reg, scan_r_next;
    logic [ADDR_W-1:0]        scan_base_reg, scan_base_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic                     sel_clear;

    // Read pipeline tags.
    ssc_pkg::scan_tag_t rd_scan_reg, rd_scan_next;
    logic               rd_upd_reg, rd_upd_next;
    logic [R_W-1:0]     rd_r_reg;
    logic [P_W-1:0]     rd_p_reg;
    logic [ADDR_W-1:0]  rd_base_reg;

    // Table RAM: {claim, allocation} per process and resource.
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [2*VALUE_WIDTH-1:0]   ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [2*VALUE_WIDTH-1:0]   ram_rdata;
    logic [VALUE_WIDTH-1:0]     rd_claim;
    logic [VALUE_WIDTH-1:0]     rd_alloc;

    assign ram_we    = in_accept & (in_kind == ssc_pkg::KIND_LOAD_CLAIM) & pidx_ok & ridx_ok;
    assign ram_waddr = ADDR_W'(32'(in_pidx) * MAX_RESOURCES + 32'(in_ridx));
    assign ram_wdata = {VALUE_WIDTH'(in_claim), VALUE_WIDTH'(in_alloc)};
    assign rd_claim  = ram_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign rd_alloc  = ram_rdata[VALUE_WIDTH-1:0];

    ssc_ram #(
        .WIDTH (2 * VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Available amounts.
    logic [AVAIL_W-1:0] avail_reg [MAX_RESOURCES];
    logic [AVAIL_W:0]   avail_sum;
    logic [AVAIL_W-1:0] avail_sat;

    assign avail_sum = {1'b0, avail_reg[rd_r_reg]} + (AVAIL_W + 1)'(rd_alloc);
    assign avail_sat = avail_sum[AVAIL_W] ? {AVAIL_W{1'b1}} : avail_sum[AVAIL_W-1:0];

    always_ff @(posedge aclk) begin
        if (in_accept && in_kind == ssc_pkg::KIND_LOAD_AVAIL && ridx_ok) begin
            avail_reg[R_W'(in_ridx)] <= AVAIL_W'(VALUE_WIDTH'(in_avail));
        end else if (rd_upd_reg) begin
            avail_reg[rd_r_reg] <= avail_sat;
        end
    end

    // Candidate selection.
    logic              sel_found;
    logic [P_W-1:0]    sel_best_p;
    logic [ADDR_W-1:0] sel_best_base;

    ssc_select #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .AVAIL_W     (AVAIL_W),
        .SUM_W       (SUM_W),
        .P_W         (P_W),
        .ADDR_W      (ADDR_W)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (sel_clear),
        .tag       (rd_scan_reg),
        .tag_p     (rd_p_reg),
        .tag_base  (rd_base_reg),
        .claim     (rd_claim),
        .alloc     (rd_alloc),
        .avail     (avail_reg[rd_r_reg]),
        .done_mark (done_reg[rd_p_reg]),
        .found     (sel_found),
        .best_p    (sel_best_p),
        .best_base (sel_best_base)
    );

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [ssc_pkg::CHOSEN_W-1:0]  m_chosen_reg, m_chosen_next;
    logic                          m_safe_reg, m_safe_next;
    logic                          m_verdict_reg, m_verdict_next;
    logic                          out_free;
    logic                          all_done;
    logic                          r_last;
    logic                          p_last;
    logic                          pass_last;

    assign out_free  = ~m_valid_reg | m_axis_tready;
    assign r_last    = ((RC_W'(scan_r_reg) + RC_W'(1)) == nres_reg);
    assign p_last    = ((PC_W'(scan_p_reg) + PC_W'(1)) == nproc_reg);
    assign pass_last = ((pass_reg + PC_W'(1)) == nproc_reg);

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            if (i < 32'(nproc_reg) && !done_reg[i]) begin
                all_done = 1'b0;
            end
        end
    end

    assign ram_raddr = (state_reg == ST_UPDATE) ? (sel_best_base + ADDR_W'(scan_r_reg))
                                                : (scan_base_reg + ADDR_W'(scan_r_reg));

    always_comb begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        scan_p_next    = scan_p_reg;
        scan_r_next    = scan_r_reg;
        scan_base_next = scan_base_reg;
        done_next      = done_reg;
        sel_clear      = 1'b0;
        rd_scan_next   = '0;
        rd_upd_next    = 1'b0;
        m_valid_next   = m_valid_reg & ~m_axis_tready;
        m_chosen_next  = m_chosen_reg;
        m_safe_next    = m_safe_reg;
        m_verdict_next = m_verdict_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_kind == ssc_pkg::KIND_RUN) begin
                    done_next      = '0;
                    pass_next      = '0;
                    scan_p_next    = '0;
                    scan_r_next    = '0;
                    scan_base_next = '0;
                    sel_clear      = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_scan_next.valid = 1'b1;
                rd_scan_next.first = (scan_r_reg == '0);
                rd_scan_next.last  = r_last;
                if (r_last) begin
                    scan_r_next    = '0;
                    scan_p_next    = scan_p_reg + P_W'(1);
                    scan_base_next = scan_base_reg + ADDR_W'(MAX_RESOURCES);
                    if (p_last) begin
                        state_next = ST_SCAN_WAIT;
                    end
                end else begin
                    scan_r_next = scan_r_reg + R_W'(1);
                end
            end
            ST_SCAN_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sel_found) begin
                    scan_r_next = '0;
                    state_next  = ST_UPDATE;
                end else if (pass_last) begin
                    state_next = ST_VERDICT;
                end else begin
                    // nothing fits: skip this pass
                    pass_next      = pass_reg + PC_W'(1);
                    scan_p_next    = '0;
                    scan_r_next    = '0;
                    scan_base_next = '0;
                    sel_clear      = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_UPDATE: begin
                rd_upd_next = 1'b1;
                if (r_last) begin
                    state_next = ST_UPD_WAIT;
                end else begin
                    scan_r_next = scan_r_reg + R_W'(1);
                end
            end
            ST_UPD_WAIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_chosen_next         = ssc_pkg::CHOSEN_W'(sel_best_p);
                    m_safe_next           = 1'b0;
                    m_verdict_next        = 1'b0;
                    done_next[sel_best_p] = 1'b1;
                    if (pass_last) begin
                        state_next = ST_VERDICT;
                    end else begin
                        pass_next      = pass_reg + PC_W'(1);
                        scan_p_next    = '0;
                        scan_r_next    = '0;
                        scan_base_next = '0;
                        sel_clear      = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_VERDICT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_chosen_next  = '0;
                    m_safe_next    = all_done;
                    m_verdict_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            done_reg    <= '0;
            rd_scan_reg <= '0;
            rd_upd_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            rd_scan_reg <= rd_scan_next;
            rd_upd_reg  <= rd_upd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Counters and payload: no reset needed; a run start loads the counters, and each result loads the payload.
    always_ff @(posedge aclk) begin
        if (in_accept && in_kind == ssc_pkg::KIND_RUN) begin
            nproc_reg <= nproc_run;
            nres_reg  <= nres_run;
        end
        pass_reg      <= pass_next;
        scan_p_reg    <= scan_p_next;
        scan_r_reg    <= scan_r_next;
        scan_base_reg <= scan_base_next;
        rd_r_reg      <= scan_r_reg;
        rd_p_reg      <= scan_p_reg;
        rd_base_reg   <= scan_base_reg;
        m_chosen_reg  <= m_chosen_next;
        m_safe_reg    <= m_safe_next;
        m_verdict_reg <= m_verdict_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_safe_reg, m_chosen_reg};
    assign m_axis_tuser  = m_verdict_reg;
    assign m_axis_tlast  = m_verdict_reg;

endmodule
